// ----- rtl/pic_pkg.sv -----
// Shared types and constants of the palette index compactor.
package pic_pkg;

    localparam int IdxW  = 8;
    localparam int CntW  = 9;
    localparam int CfgAw = 2;
    localparam int CfgDw = 9;

    typedef logic [IdxW-1:0] t_idx;
    typedef logic [CntW-1:0] t_cnt;

    typedef enum logic [CfgAw-1:0] {
        CFG_TRANSP_EN  = 2'd0,
        CFG_TRANSP_IDX = 2'd1,
        CFG_OLD_COUNT  = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        t_idx pixel_index;
        logic last_pixel;
    } t_pix_req;

    typedef struct packed {
        t_idx new_index;
        logic first_seen;
        t_idx original_index;
        logic index_error;
        logic frame_done;
        t_cnt colors_used;
        logic transparent_found;
        t_idx new_transparent_index;
    } t_res;

    // first-occurrence decision handed from the seen tracker to the pipeline
    typedef struct packed {
        logic first;
        t_idx nidx_new;
        t_cnt used;
    } t_seen_res;

endpackage

// ----- rtl/pic_in_if.sv -----
// Pixel request channel: valid/ready with pixel payload.
interface pic_in_if;
    logic              valid;
    logic              ready;
    pic_pkg::t_pix_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/pic_out_if.sv -----
// Result channel: valid/ready with renumbered pixel payload.
interface pic_out_if;
    logic          valid;
    logic          ready;
    pic_pkg::t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/pic_map_ram.sv -----
// Old-to-new index map: one write port, one registered read port.
module pic_map_ram #(
    parameter int Depth = 256,
    parameter int Aw    = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [Aw-1:0]     i_waddr,
    input  pic_pkg::t_idx     i_wdata,
    input  logic              i_re,
    input  logic [Aw-1:0]     i_raddr,
    output pic_pkg::t_idx     o_rdata
);

    pic_pkg::t_idx r_mem [Depth];
    pic_pkg::t_idx r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/pic_seen.sv -----
// Seen flags and color counter; decides first occurrence per pixel.
module pic_seen #(
    parameter int PaletteSize = 256,
    parameter int Aw          = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_acc,
    input  logic [Aw-1:0]         i_addr,
    input  logic                  i_last,
    output pic_pkg::t_seen_res    o_res
);

    localparam int CW = $clog2(PaletteSize + 1);

    logic [PaletteSize-1:0] r_seen;
    logic [CW-1:0]          r_cnt;
    logic [CW-1:0]          n_cnt;
    logic                   w_first;

    assign w_first = ~r_seen[i_addr];

    // saturates at the palette size
    always_comb begin
        n_cnt = r_cnt;
        if (w_first && (r_cnt < CW'(PaletteSize))) begin
            n_cnt = r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            r_cnt  <= '0;
        end else if (i_acc) begin
            if (i_last) begin
                r_seen <= '0;
                r_cnt  <= '0;
            end else begin
                r_seen[i_addr] <= 1'b1;
                r_cnt          <= n_cnt;
            end
        end
    end

    assign o_res.first    = w_first;
    assign o_res.nidx_new = pic_pkg::t_idx'(r_cnt);
    assign o_res.used     = pic_pkg::t_cnt'(n_cnt);

endmodule

// ----- rtl/palette_index_compactor.sv -----
// Top level of the palette index compactor.
//
// Usage: pixels of a frame come in raster order on i_pix (valid/ready), one
// request per pixel carrying the old palette index and a last-pixel mark.
// Each request yields exactly one result on o_res: the dense new index,
// a first-seen flag, the old index and an out-of-palette flag. The result
// of the last pixel also carries the color count and the renumbered
// transparent index; the frame state is then cleared for the next frame.
// Path: an accepted request is registered in stage 1 and then in the
// output register, which drives o_res.valid. Throughput: one pixel per
// cycle while o_res is not stalled, set by the single map read per pixel
// (synchronous RAM, one read and one write port); seen flags live in flops
// and are read the cycle the request is accepted, so no forwarding is needed.
// A stalled receiver holds the output register; the middle stage then
// fills and i_pix.ready drops. Reset clears flags, counter, pipeline and
// configuration (old_color_count resets to 256); the map RAM is not
// cleared, its entries are only used once their seen flag is set.
// Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data while idle.
module palette_index_compactor #(
    parameter int PALETTE_SIZE = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [pic_pkg::CfgAw-1:0]   i_cfg_idx,
    input  logic [pic_pkg::CfgDw-1:0]   i_cfg_data,
    pic_in_if.sink                      i_pix,
    pic_out_if.source                   o_res
);

    localparam int AW = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;

    // configuration
    logic              r_tr_en;
    pic_pkg::t_idx     r_tr_idx;
    pic_pkg::t_cnt     r_old_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tr_en   <= 1'b0;
            r_tr_idx  <= '0;
            r_old_cnt <= pic_pkg::t_cnt'(256);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pic_pkg::CFG_TRANSP_EN:  r_tr_en   <= i_cfg_data[0];
                pic_pkg::CFG_TRANSP_IDX: r_tr_idx  <= i_cfg_data[7:0];
                pic_pkg::CFG_OLD_COUNT:  r_old_cnt <= i_cfg_data;
                default: ; // unused index, ignored
            endcase
        end
    end

    // handshake
    logic w_in_acc;
    logic w_adv;
    logic r_s1_vld;
    logic r_out_vld;

    assign w_adv       = ~r_out_vld | o_res.ready;
    assign i_pix.ready = ~r_s1_vld | w_adv;
    assign w_in_acc    = i_pix.valid & i_pix.ready;

    // table address: pixel index folded into the table (aliasing when small)
    logic [AW-1:0] w_addr_lut [256];
    for (genvar k = 0; k < 256; k++) begin : g_lut
        assign w_addr_lut[k] = AW'(k % PALETTE_SIZE);
    end

    logic [AW-1:0] w_addr;
    logic          w_err;
    logic          w_match;

    assign w_addr  = w_addr_lut[i_pix.data.pixel_index];
    assign w_err   = ({1'b0, i_pix.data.pixel_index} >= r_old_cnt) ||
                     ({1'b0, i_pix.data.pixel_index} >= pic_pkg::t_cnt'(PALETTE_SIZE));
    assign w_match = r_tr_en && (i_pix.data.pixel_index == r_tr_idx);

    // stage 0: first-occurrence decision, map write on first sight
    pic_pkg::t_seen_res w_seen;
    pic_pkg::t_idx      w_rdata;

    pic_seen #(
        .PaletteSize (PALETTE_SIZE),
        .Aw          (AW)
    ) u_seen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (w_in_acc),
        .i_addr  (w_addr),
        .i_last  (i_pix.data.last_pixel),
        .o_res   (w_seen)
    );

    // an entry is written in the same cycle its seen flag is set, so any
    // later read that needs it sees the written value
    pic_map_ram #(
        .Depth (PALETTE_SIZE),
        .Aw    (AW)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_in_acc & w_seen.first),
        .i_waddr (w_addr),
        .i_wdata (w_seen.nidx_new),
        .i_re    (w_in_acc),
        .i_raddr (w_addr),
        .o_rdata (w_rdata)
    );

    // stage 1 holds the request while the map read completes
    pic_pkg::t_idx r_s1_pix;
    logic          r_s1_last;
    logic          r_s1_err;
    logic          r_s1_match;
    logic          r_s1_first;
    pic_pkg::t_idx r_s1_nidx_new;
    pic_pkg::t_cnt r_s1_used;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (i_pix.ready) begin
            r_s1_vld <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_pix      <= i_pix.data.pixel_index;
            r_s1_last     <= i_pix.data.last_pixel;
            r_s1_err      <= w_err;
            r_s1_match    <= w_match;
            r_s1_first    <= w_seen.first;
            r_s1_nidx_new <= w_seen.nidx_new;
            r_s1_used     <= w_seen.used;
        end
    end

    // transparent tracking, updated as stage 1 retires
    logic          r_tr_hit;
    pic_pkg::t_idx r_tr_new;
    pic_pkg::t_idx w_nidx;
    logic          w_hit_eff;
    pic_pkg::t_idx w_tnew_eff;
    logic          w_tfound;
    logic          w_s1_go;
    pic_pkg::t_res n_out;

    assign w_nidx     = r_s1_first ? r_s1_nidx_new : w_rdata;
    assign w_hit_eff  = r_tr_hit | r_s1_match;
    assign w_tnew_eff = r_s1_match ? w_nidx : r_tr_new;
    assign w_tfound   = r_s1_last & w_hit_eff & r_tr_en;
    assign w_s1_go    = r_s1_vld & w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tr_hit <= 1'b0;
            r_tr_new <= '0;
        end else if (w_s1_go) begin
            if (r_s1_last) begin
                r_tr_hit <= 1'b0;
                r_tr_new <= '0;
            end else begin
                r_tr_hit <= w_hit_eff;
                r_tr_new <= w_tnew_eff;
            end
        end
    end

    always_comb begin
        n_out.new_index             = w_nidx;
        n_out.first_seen            = r_s1_first;
        n_out.original_index        = r_s1_pix;
        n_out.index_error           = r_s1_err;
        n_out.frame_done            = r_s1_last;
        n_out.colors_used           = r_s1_last ? r_s1_used : '0;
        n_out.transparent_found     = w_tfound;
        n_out.new_transparent_index = w_tfound ? w_tnew_eff : '0;
    end

    // output register
    pic_pkg::t_res r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_go) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid = r_out_vld;
    assign o_res.data  = r_out;

    // checks
    a_s1_fill : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_s1_vld)
        else $error("accepted request did not reach stage 1");

    a_s1_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !w_adv) |=> (r_s1_vld && $stable(r_s1_pix) && $stable(r_s1_last)))
        else $error("stage 1 changed while blocked");

    a_frame_fields : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out.frame_done) |->
            (r_out.colors_used == '0 && !r_out.transparent_found))
        else $error("frame summary set on a non-final pixel");

    a_tnew_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out.transparent_found) |-> (r_out.new_transparent_index == '0))
        else $error("transparent index set without a hit");

endmodule
